>>> sv/polynomial_term_deque_unit_assert.svh
// Assertion macros used by the polynomial term deque RTL
`ifndef POLYNOMIAL_TERM_DEQUE_UNIT_ASSERT_SVH
`define POLYNOMIAL_TERM_DEQUE_UNIT_ASSERT_SVH

// expression must hold at every clock edge out of reset
`define PTD_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define PTD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/ptd_pkg.sv
// Types, codes and widths for the polynomial term deque
package ptd_pkg;

   // field widths
   localparam int KIND_W   = 3;
   localparam int DEG_W    = 16;
   localparam int COEF_W   = 32;
   localparam int STATUS_W = 2;
   localparam int NUM_W    = 5;

   localparam int DEPTH_DEFAULT = 16;

   // request kinds
   localparam logic [KIND_W-1:0] K_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] K_PUSH_BACK  = 3'd1;
   localparam logic [KIND_W-1:0] K_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] K_POP_BACK   = 3'd3;
   localparam logic [KIND_W-1:0] K_REMOVE     = 3'd4;
   localparam logic [KIND_W-1:0] K_FIND       = 3'd5;
   localparam logic [KIND_W-1:0] K_LOOKUP     = 3'd6;
   localparam logic [KIND_W-1:0] K_CLEAR      = 3'd7;

   // response status
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   // one stored term
   typedef struct packed {
      logic signed [DEG_W-1:0]  degree;
      logic signed [COEF_W-1:0] coef;
   } term_type;

endpackage

>>> sv/ptd_term_ram.sv
// Term memory: one write port, one registered read port
module ptd_term_ram #(
   parameter int Depth = ptd_pkg::DEPTH_DEFAULT,
   localparam int IdxW = $clog2(Depth)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IdxW-1:0]   wr_addr,
   input  ptd_pkg::term_type wr_data,
   input  logic              rd_en,
   input  logic [IdxW-1:0]   rd_addr,
   output ptd_pkg::term_type rd_data
);

   ptd_pkg::term_type mem [Depth];
   ptd_pkg::term_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/polynomial_term_deque_unit.sv
// Polynomial term deque: sequencer, ring pointers and shared match compare
//
//   channel   | ports                                      | handshake
//   ----------+--------------------------------------------+----------------------------
//   request   | req_kind, req_in_degree, req_in_coef       | start & !busy
//   response  | rsp_status, rsp_out_degree, rsp_out_coef,  | rsp_strobe, one cycle
//             | rsp_out_number                             |
//
// Push, clear and a pop of an empty queue answer from the execute state; other pops
// read the term memory first and answer from the pop state. Remove, find and lookup
// walk the live entries through the one read port of the term memory and the match
// compare, one entry a cycle. busy stays high from the request until the strobe cycle;
// a new request may be taken in the strobe cycle. Synchronous reset empties the queue;
// the term memory itself is not cleared. The receiver cannot stall the response.
`include "polynomial_term_deque_unit_assert.svh"

module polynomial_term_deque_unit #(
   parameter int DEPTH = ptd_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ptd_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [ptd_pkg::DEG_W-1:0]    req_in_degree,
   input  logic signed [ptd_pkg::COEF_W-1:0]   req_in_coef,
   output logic                                rsp_strobe,
   output logic [ptd_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [ptd_pkg::DEG_W-1:0]    rsp_out_degree,
   output logic signed [ptd_pkg::COEF_W-1:0]   rsp_out_coef,
   output logic [ptd_pkg::NUM_W-1:0]           rsp_out_number
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W:0]   DEPTH_X = (CNT_W + 1)'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_POP  = 2'd2;
   localparam logic [1:0] S_SCAN = 2'd3;

   // ring position of an offset from the front: one compare and subtract
   function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[IDX_W-1:0];
   endfunction

   // count or position onto the 5-bit number field
   function automatic logic [ptd_pkg::NUM_W-1:0] to_num(input logic [CNT_W-1:0] v);
      logic [CNT_W+ptd_pkg::NUM_W-1:0] wide;
      wide = (CNT_W + ptd_pkg::NUM_W)'(v);
      return wide[ptd_pkg::NUM_W-1:0];
   endfunction

   logic [1:0] state_ff, state_in;
   logic [ptd_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic signed [ptd_pkg::DEG_W-1:0]  deg_ff, deg_in;
   logic signed [ptd_pkg::COEF_W-1:0] coef_ff, coef_in;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;    // next offset to read
   logic             pend_ff, pend_in;    // read data of offset scan_ff-1 is valid
   logic [CNT_W-1:0] keep_ff, keep_in;    // entries kept by remove
   logic [CNT_W-1:0] hit_ff, hit_in;      // entries dropped by remove

   logic rsp_strobe_ff, rsp_strobe_in;
   logic [ptd_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic signed [ptd_pkg::DEG_W-1:0]  rsp_degree_ff, rsp_degree_in;
   logic signed [ptd_pkg::COEF_W-1:0] rsp_coef_ff, rsp_coef_in;
   logic [ptd_pkg::NUM_W-1:0]         rsp_number_ff, rsp_number_in;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   ptd_pkg::term_type ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   ptd_pkg::term_type ram_rd_data;

   logic issue_go;
   logic term_match;

   ptd_term_ram #(
      .Depth(DEPTH)
   ) u_term_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared compare: degree always, coefficient unless looking up
   assign term_match = (ram_rd_data.degree == deg_ff) &&
                       ((kind_ff == ptd_pkg::K_LOOKUP) || (ram_rd_data.coef == coef_ff));
   assign issue_go   = (scan_ff < count_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      deg_in        = deg_ff;
      coef_in       = coef_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      keep_in       = keep_ff;
      hit_in        = hit_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ptd_pkg::ST_OK;
      rsp_degree_in = '0;
      rsp_coef_in   = '0;
      rsp_number_in = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               deg_in   = req_in_degree;
               coef_in  = req_in_coef;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            unique case (kind_ff)
               ptd_pkg::K_PUSH_FRONT, ptd_pkg::K_PUSH_BACK: begin
                  state_in      = S_IDLE;
                  rsp_strobe_in = 1'b1;
                  if (count_ff == DEPTH_C) begin
                     rsp_status_in = ptd_pkg::ST_FULL;
                  end else begin
                     ram_wr_en          = 1'b1;
                     ram_wr_data.degree = deg_ff;
                     ram_wr_data.coef   = coef_ff;
                     count_in           = count_ff + CNT_W'(1);
                     if (kind_ff == ptd_pkg::K_PUSH_FRONT) begin
                        front_in    = (front_ff == '0) ? LAST_IDX : front_ff - IDX_W'(1);
                        ram_wr_addr = front_in;
                     end else begin
                        ram_wr_addr = ring_pos(front_ff, count_ff);
                     end
                  end
               end
               ptd_pkg::K_POP_FRONT, ptd_pkg::K_POP_BACK: begin
                  if (count_ff == '0) begin
                     state_in      = S_IDLE;
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ptd_pkg::ST_EMPTY;
                  end else begin
                     ram_rd_en = 1'b1;
                     if (kind_ff == ptd_pkg::K_POP_FRONT) begin
                        ram_rd_addr = front_ff;
                     end else begin
                        ram_rd_addr = ring_pos(front_ff, count_ff - CNT_W'(1));
                     end
                     state_in = S_POP;
                  end
               end
               ptd_pkg::K_REMOVE, ptd_pkg::K_FIND, ptd_pkg::K_LOOKUP: begin
                  scan_in  = '0;
                  keep_in  = '0;
                  hit_in   = '0;
                  state_in = S_SCAN;
               end
               default: begin
                  // clear
                  front_in      = '0;
                  count_in      = '0;
                  state_in      = S_IDLE;
                  rsp_strobe_in = 1'b1;
               end
            endcase
         end

         S_POP: begin
            rsp_strobe_in = 1'b1;
            rsp_degree_in = ram_rd_data.degree;
            rsp_coef_in   = ram_rd_data.coef;
            count_in      = count_ff - CNT_W'(1);
            if (kind_ff == ptd_pkg::K_POP_FRONT) begin
               front_in = ring_pos(front_ff, CNT_W'(1));
            end
            state_in = S_IDLE;
         end

         default: begin
            // S_SCAN: read one entry a cycle, compare the one read before
            if (issue_go) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ring_pos(front_ff, scan_ff);
               scan_in     = scan_ff + CNT_W'(1);
               pend_in     = 1'b1;
            end
            priority if (pend_ff) begin
               if (kind_ff == ptd_pkg::K_REMOVE) begin
                  if (term_match) begin
                     hit_in = hit_ff + CNT_W'(1);
                  end else begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = ring_pos(front_ff, keep_ff);
                     ram_wr_data = ram_rd_data;
                     keep_in     = keep_ff + CNT_W'(1);
                  end
               end else if (term_match) begin
                  // first hit ends find and lookup
                  pend_in       = 1'b0;
                  state_in      = S_IDLE;
                  rsp_strobe_in = 1'b1;
                  if (kind_ff == ptd_pkg::K_FIND) begin
                     rsp_number_in = to_num(scan_ff - CNT_W'(1));
                  end else begin
                     rsp_coef_in = ram_rd_data.coef;
                  end
               end
            end else if (!issue_go) begin
               // walk finished
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               if (kind_ff == ptd_pkg::K_REMOVE) begin
                  count_in      = keep_ff;
                  rsp_number_in = to_num(hit_ff);
               end else begin
                  rsp_status_in = ptd_pkg::ST_NOTFOUND;
               end
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         front_ff      <= '0;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // request, walk and response payload
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      deg_ff        <= deg_in;
      coef_ff       <= coef_in;
      scan_ff       <= scan_in;
      keep_ff       <= keep_in;
      hit_ff        <= hit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_degree_ff <= rsp_degree_in;
      rsp_coef_ff   <= rsp_coef_in;
      rsp_number_ff <= rsp_number_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_degree = rsp_degree_ff;
   assign rsp_out_coef   = rsp_coef_ff;
   assign rsp_out_number = rsp_number_ff;

   // checks
   `PTD_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= DEPTH_C, "entry count above depth")
   `PTD_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "request not taken")
   `PTD_ASSERT_IMPL(a_strobe_idle, clock, reset, rsp_strobe, !busy, "response while busy")
   `PTD_ASSERT_NEXT(a_single_rsp, clock, reset, rsp_strobe, !rsp_strobe, "response repeated")
   `PTD_ASSERT_IMPL(a_clear_empty, clock, reset, rsp_strobe && kind_ff == ptd_pkg::K_CLEAR, count_ff == '0 && front_ff == '0, "clear left entries")

endmodule
